>>> rtl/vrt_pkg.sv
// Shared types and constants for the voxel ray traversal block.
package vrt_pkg;

    localparam int DIV_BITS = 32;
    localparam int CNT_BITS = $clog2(DIV_BITS);
    localparam int MAG_BITS = 16;
    localparam int NUM_BITS = 9;
    localparam int NUM_SHIFT = DIV_BITS - NUM_BITS;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    localparam logic [1:0] SGN_NONE = 2'd0;
    localparam logic [1:0] SGN_POS  = 2'd1;
    localparam logic [1:0] SGN_NEG  = 2'd3;

    localparam logic [DIV_BITS-1:0] CROSS_DIVIDEND = {1'b1, {(DIV_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV
    } t_state;

endpackage

>>> rtl/vrt_if.sv
// Handshake channels for ray commands and voxel results.
interface vrt_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;

    modport source (output valid, func, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, func, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface vrt_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] voxel_x;
    logic signed [23:0] voxel_y;
    logic signed [23:0] voxel_z;
    logic               ray_valid;

    modport source (output valid, voxel_x, voxel_y, voxel_z, ray_valid, input ready);
    modport sink (input valid, voxel_x, voxel_y, voxel_z, ray_valid, output ready);
endinterface

>>> rtl/voxel_ray_traversal_3d_top.sv
// Top level of the 3D voxel ray traversal walker.
// A step result is registered; steps sustain one item per cycle while the output is taken
// and no start is being set up. Reset is synchronous and clears the ray and its state.
// A start transfer runs a shared restoring divider, one quotient bit per cycle: each axis with
// a nonzero direction needs two divisions, each after a setup step, and a start with any
// nonzero direction holds the input until every axis is set up.
module voxel_ray_traversal_3d_top
    import vrt_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int TIME_BITS  = 48
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vrt_in_if.sink    i_in,
    vrt_out_if.source o_out
);

    localparam logic [TIME_BITS-1:0] T_MAX = {TIME_BITS{1'b1}};

    t_state r_state, n_state;

    logic [COORD_BITS-1:0] r_pos   [3];
    logic [1:0]            r_sign  [3];
    logic [TIME_BITS-1:0]  r_nb    [3];
    logic [TIME_BITS-1:0]  r_cross [3];
    logic                  r_active;

    logic [MAG_BITS-1:0]   r_mag   [3];
    logic [NUM_BITS-1:0]   r_num   [3];
    logic [1:0]            r_axis;
    logic                  r_phase;

    logic [MAG_BITS:0]     r_rem;
    logic [DIV_BITS-1:0]   r_dq;
    logic [CNT_BITS-1:0]   r_cnt;

    logic                  r_out_valid;
    logic [23:0]           r_out_x, r_out_y, r_out_z;
    logic                  r_out_ray;

    logic                  in_fire;
    logic                  dir_all_zero;
    logic [31:0]           org   [3];
    logic [15:0]           dir   [3];
    logic [1:0]            step_axis;
    logic [COORD_BITS-1:0] stepped_pos [3];
    logic [TIME_BITS:0]    time_sum;
    logic [MAG_BITS:0]     rem_shift;
    logic                  q_bit;
    logic [DIV_BITS-1:0]   quotient;
    logic                  last_axis;

    assign in_fire = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);

    assign org[0] = i_in.origin_x;
    assign org[1] = i_in.origin_y;
    assign org[2] = i_in.origin_z;
    assign dir[0] = i_in.dir_x;
    assign dir[1] = i_in.dir_y;
    assign dir[2] = i_in.dir_z;
    assign dir_all_zero = (dir[0] == '0) && (dir[1] == '0) && (dir[2] == '0);

    assign last_axis = (r_axis == 2'd2);

    always_comb begin
        if (r_nb[0] < r_nb[1] && r_nb[0] < r_nb[2]) begin
            step_axis = 2'd0;
        end else if (r_nb[1] < r_nb[2]) begin
            step_axis = 2'd1;
        end else begin
            step_axis = 2'd2;
        end
        time_sum = {1'b0, r_nb[step_axis]} + {1'b0, r_cross[step_axis]};
        for (int a = 0; a < 3; a++) begin
            stepped_pos[a] = r_pos[a];
        end
        case (r_sign[step_axis])
            SGN_POS: stepped_pos[step_axis] = r_pos[step_axis] + COORD_BITS'(1);
            SGN_NEG: stepped_pos[step_axis] = r_pos[step_axis] - COORD_BITS'(1);
            default: stepped_pos[step_axis] = r_pos[step_axis];
        endcase
    end

    assign rem_shift = {r_rem[MAG_BITS-1:0], r_dq[DIV_BITS-1]};
    assign q_bit     = (rem_shift >= {1'b0, r_mag[r_axis]});
    assign quotient  = {r_dq[DIV_BITS-2:0], q_bit};

    function automatic logic [23:0] out_coord(input logic [COORD_BITS-1:0] v);
        logic signed [63:0] w;
        w = 64'(signed'(v));
        return w[23:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && i_in.func == FUNC_START && !dir_all_zero) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (r_sign[r_axis] != SGN_NONE) begin
                    n_state = ST_DIV;
                end else if (last_axis) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_BITS'(DIV_BITS - 1)) begin
                    n_state = (r_phase && last_axis) ? ST_IDLE : ST_SETUP;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_pos[a]   <= '0;
                r_sign[a]  <= SGN_NONE;
                r_nb[a]    <= T_MAX;
                r_cross[a] <= T_MAX;
            end
            r_active <= 1'b0;
            r_axis   <= '0;
            r_phase  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_fire && i_in.func == FUNC_START) begin
                        if (dir_all_zero) begin
                            r_active <= 1'b0;
                        end else begin
                            r_active <= 1'b0;
                            r_axis   <= '0;
                            r_phase  <= 1'b0;
                            for (int a = 0; a < 3; a++) begin
                                r_pos[a] <= COORD_BITS'(64'(signed'(org[a][31:8])));
                                if (dir[a] == '0) begin
                                    r_sign[a]  <= SGN_NONE;
                                    r_nb[a]    <= T_MAX;
                                    r_cross[a] <= T_MAX;
                                end else if (dir[a][15]) begin
                                    r_sign[a] <= SGN_NEG;
                                    r_mag[a]  <= MAG_BITS'(-dir[a]);
                                    r_num[a]  <= (org[a][7:0] == '0) ? NUM_BITS'(256)
                                                                     : {1'b0, org[a][7:0]};
                                end else begin
                                    r_sign[a] <= SGN_POS;
                                    r_mag[a]  <= dir[a];
                                    r_num[a]  <= NUM_BITS'(256) - {1'b0, org[a][7:0]};
                                end
                            end
                        end
                    end else if (in_fire && r_active) begin
                        r_pos <= stepped_pos;
                        r_nb[step_axis] <= time_sum[TIME_BITS] ? T_MAX
                                                               : time_sum[TIME_BITS-1:0];
                    end
                end
                ST_SETUP: begin
                    r_cnt <= '0;
                    r_rem <= '0;
                    r_dq  <= r_phase ? CROSS_DIVIDEND
                                     : {r_num[r_axis], {NUM_SHIFT{1'b0}}};
                    if (r_sign[r_axis] == SGN_NONE) begin
                        r_axis <= r_axis + 2'd1;
                        if (last_axis) begin
                            r_active <= 1'b1;
                        end
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + CNT_BITS'(1);
                    r_rem <= q_bit ? rem_shift - {1'b0, r_mag[r_axis]} : rem_shift;
                    r_dq  <= quotient;
                    if (r_cnt == CNT_BITS'(DIV_BITS - 1)) begin
                        if (r_phase) begin
                            r_cross[r_axis] <= TIME_BITS'(quotient);
                            r_phase <= 1'b0;
                            r_axis  <= r_axis + 2'd1;
                            if (last_axis) begin
                                r_active <= 1'b1;
                            end
                        end else begin
                            r_nb[r_axis] <= TIME_BITS'(quotient);
                            r_phase <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && i_in.func == FUNC_STEP) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_in.func == FUNC_STEP) begin
            if (r_active) begin
                r_out_x   <= out_coord(stepped_pos[0]);
                r_out_y   <= out_coord(stepped_pos[1]);
                r_out_z   <= out_coord(stepped_pos[2]);
                r_out_ray <= 1'b1;
            end else begin
                r_out_x   <= '0;
                r_out_y   <= '0;
                r_out_z   <= '0;
                r_out_ray <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.voxel_x   = r_out_x;
    assign o_out.voxel_y   = r_out_y;
    assign o_out.voxel_z   = r_out_z;
    assign o_out.ray_valid = r_out_ray;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the 3D voxel ray traversal walker.
`timescale 1ns / 100ps

module tb
    import vrt_pkg::*;
();

    localparam int          COORD_W       = 24;
    localparam int          TIME_W        = 48;
    localparam logic [47:0] T_MAX         = {TIME_W{1'b1}};
    localparam int          RANDOM_ITEMS  = 1000;
    localparam int          BURST_STEPS   = 150;
    localparam int          SETTLE_CYCLES = 250;
    localparam int          CYCLE_LIMIT   = 3000000;

    typedef struct packed {
        logic             func;
        logic [2:0][31:0] origin;
        logic [2:0][15:0] dir;
    } t_ray_cmd;

    typedef struct packed {
        logic [2:0][23:0] voxel;
        logic             ray_valid;
    } t_voxel_result;

    logic i_clk;
    logic i_rst_n;

    vrt_in_if  cmd_if ();
    vrt_out_if vox_if ();

    voxel_ray_traversal_3d_top #(
        .COORD_BITS(COORD_W),
        .TIME_BITS (TIME_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_if),
        .o_out  (vox_if)
    );

    logic [COORD_W-1:0] walk_pos [3];
    logic [1:0]         walk_sign [3];
    logic [TIME_W-1:0]  walk_t_next [3];
    logic [TIME_W-1:0]  walk_t_cross [3];
    bit                 walk_active;

    t_voxel_result expected_voxels[$];
    t_voxel_result got_voxel;
    t_voxel_result want_voxel;

    bit idle_on;
    int fail_count;
    int loads_sent;
    int steps_sent;
    int results_checked;
    int cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_voxels.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic walk_reset();
        for (int a = 0; a < 3; a++) begin
            walk_pos[a]     = '0;
            walk_sign[a]    = SGN_NONE;
            walk_t_next[a]  = T_MAX;
            walk_t_cross[a] = T_MAX;
        end
        walk_active = 1'b0;
    endtask

    task automatic walk_load(input t_ray_cmd c);
        logic [16:0] mag;
        logic [8:0]  span;
        logic [7:0]  frac;
        logic [63:0] num;
        if (c.dir == '0) begin
            walk_active = 1'b0;
            return;
        end
        for (int a = 0; a < 3; a++) begin
            walk_pos[a] = c.origin[a][31:8];
            frac = c.origin[a][7:0];
            if (c.dir[a] == 16'h0000) begin
                walk_sign[a]    = SGN_NONE;
                walk_t_next[a]  = T_MAX;
                walk_t_cross[a] = T_MAX;
            end else begin
                if (c.dir[a][15]) begin
                    mag          = 17'h10000 - {1'b0, c.dir[a]};
                    span         = (frac == 8'd0) ? 9'd256 : {1'b0, frac};
                    walk_sign[a] = SGN_NEG;
                end else begin
                    mag          = {1'b0, c.dir[a]};
                    span         = 9'd256 - {1'b0, frac};
                    walk_sign[a] = SGN_POS;
                end
                num             = 64'(span) << 23;
                walk_t_next[a]  = TIME_W'(num / 64'(mag));
                walk_t_cross[a] = TIME_W'(64'h8000_0000 / 64'(mag));
            end
        end
        walk_active = 1'b1;
    endtask

    function automatic t_voxel_result walk_advance();
        t_voxel_result r;
        int            a;
        logic [48:0]   sum;
        r = '0;
        if (!walk_active) return r;
        if (walk_t_next[0] < walk_t_next[1] && walk_t_next[0] < walk_t_next[2])
            a = 0;
        else if (walk_t_next[1] < walk_t_next[2])
            a = 1;
        else
            a = 2;
        if (walk_sign[a] == SGN_POS)
            walk_pos[a] = walk_pos[a] + COORD_W'(1);
        else if (walk_sign[a] == SGN_NEG)
            walk_pos[a] = walk_pos[a] - COORD_W'(1);
        sum = {1'b0, walk_t_next[a]} + {1'b0, walk_t_cross[a]};
        walk_t_next[a] = sum[48] ? T_MAX : sum[47:0];
        for (int k = 0; k < 3; k++) r.voxel[k] = walk_pos[k];
        r.ray_valid = 1'b1;
        return r;
    endfunction

    function automatic t_ray_cmd make_start(input logic [31:0] ox, oy, oz,
                                            input logic [15:0] dx, dy, dz);
        t_ray_cmd c;
        c.func      = FUNC_START;
        c.origin[0] = ox;
        c.origin[1] = oy;
        c.origin[2] = oz;
        c.dir[0]    = dx;
        c.dir[1]    = dy;
        c.dir[2]    = dz;
        return c;
    endfunction

    function automatic t_ray_cmd make_step();
        t_ray_cmd c;
        c = make_start($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                       16'($urandom));
        c.func = FUNC_STEP;
        return c;
    endfunction

    function automatic logic [15:0] pick_dir();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h8000;
            2:       return 16'h7FFF;
            3:       return 16'($urandom_range(1, 64));
            4:       return -16'($urandom_range(1, 64));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_origin();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000 + 32'($urandom_range(0, 1023));
            1:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 1023));
            2:       return 32'($urandom_range(0, 4095)) - 32'd2048;
            default: return $urandom;
        endcase
    endfunction

    // Valid is left high after a transfer so back-to-back items go without a gap.
    task automatic send_cmd(input t_ray_cmd c);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.func     <= c.func;
        cmd_if.origin_x <= c.origin[0];
        cmd_if.origin_y <= c.origin[1];
        cmd_if.origin_z <= c.origin[2];
        cmd_if.dir_x    <= c.dir[0];
        cmd_if.dir_y    <= c.dir[1];
        cmd_if.dir_z    <= c.dir[2];
        do @(posedge i_clk); while (!cmd_if.ready);
        if (c.func == FUNC_STEP) begin
            expected_voxels.push_back(walk_advance());
            steps_sent++;
        end else begin
            walk_load(c);
            loads_sent++;
        end
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_voxels.size() != 0);
    endtask

    initial begin
        vox_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            int stall;
            stall = idle_on ? $urandom_range(0, 8) : 0;
            if (stall > 0) begin
                vox_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            vox_if.ready <= 1'b1;
            do @(posedge i_clk); while (!vox_if.valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && vox_if.valid && vox_if.ready) begin
            got_voxel.voxel[0]  = vox_if.voxel_x;
            got_voxel.voxel[1]  = vox_if.voxel_y;
            got_voxel.voxel[2]  = vox_if.voxel_z;
            got_voxel.ray_valid = vox_if.ray_valid;
            results_checked++;
            if (expected_voxels.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("Unexpected voxel result (%0d,%0d,%0d) ray_valid %0b.",
                             $signed(got_voxel.voxel[0]), $signed(got_voxel.voxel[1]),
                             $signed(got_voxel.voxel[2]), got_voxel.ray_valid);
            end else begin
                want_voxel = expected_voxels.pop_front();
                if (got_voxel.voxel[0] !== want_voxel.voxel[0] ||
                    got_voxel.voxel[1] !== want_voxel.voxel[1] ||
                    got_voxel.voxel[2] !== want_voxel.voxel[2] ||
                    got_voxel.ray_valid !== want_voxel.ray_valid) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Voxel mismatch: expected (%0d,%0d,%0d) valid %0b, %s",
                                 $signed(want_voxel.voxel[0]), $signed(want_voxel.voxel[1]),
                                 $signed(want_voxel.voxel[2]), want_voxel.ray_valid,
                                 $sformatf("got (%0d,%0d,%0d) valid %0b",
                                           $signed(got_voxel.voxel[0]),
                                           $signed(got_voxel.voxel[1]),
                                           $signed(got_voxel.voxel[2]),
                                           got_voxel.ray_valid));
                end
            end
        end
    end

    task automatic test_inactive_steps();
        send_cmd(make_step());
        send_cmd(make_step());
        send_cmd(make_start($urandom, $urandom, $urandom, 16'h0000, 16'h0000, 16'h0000));
        send_cmd(make_step());
    endtask

    task automatic test_directed_rays();
        t_ray_cmd rays [7];
        rays[0] = make_start(32'h0000_0080, 32'hFFFF_FF40, 32'h0000_0000,
                             16'h4000, 16'hC000, 16'h2000);
        rays[1] = make_start(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             16'h7FFF, 16'h0000, 16'h0000);
        rays[2] = make_start(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             16'h8000, 16'h0000, 16'h0000);
        rays[3] = make_start(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                             16'h1000, 16'h1000, 16'h1000);
        rays[4] = make_start(32'h0000_0100, 32'h0000_01FF, 32'h0000_0000,
                             16'h0001, 16'hFFFF, 16'h0000);
        rays[5] = make_start($urandom, $urandom, $urandom, 16'h0000, 16'h0000, 16'h8001);
        rays[6] = make_start($urandom, $urandom, $urandom, 16'h0000, 16'h7FFF, 16'h0000);
        foreach (rays[i]) begin
            send_cmd(rays[i]);
            send_cmd(make_step());
            send_cmd(make_step());
        end
        wait_drained();
    endtask

    // A unit negative direction moves along one axis on every step, here with no idle cycles.
    task automatic test_step_burst();
        idle_on = 1'b0;
        send_cmd(make_start({24'($urandom_range(0, 255)), 8'h00}, $urandom, $urandom,
                            16'hFFFF, 16'h0000, 16'h0000));
        repeat (BURST_STEPS) send_cmd(make_step());
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_random_rays();
        int  sent;
        int  burst;
        bit  paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            case ($urandom_range(0, 9))
                0: send_cmd(make_start($urandom, $urandom, $urandom,
                                       16'h0000, 16'h0000, 16'h0000));
                1: ;
                default: send_cmd(make_start(pick_origin(), pick_origin(), pick_origin(),
                                             pick_dir(), pick_dir(), pick_dir()));
            endcase
            burst = $urandom_range(1, 24);
            repeat (burst) send_cmd(make_step());
            sent += burst + 1;
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        cmd_if.valid    <= 1'b0;
        cmd_if.func     <= FUNC_START;
        cmd_if.origin_x <= '0;
        cmd_if.origin_y <= '0;
        cmd_if.origin_z <= '0;
        cmd_if.dir_x    <= '0;
        cmd_if.dir_y    <= '0;
        cmd_if.dir_z    <= '0;
        idle_on = 1'b1;
        walk_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_inactive_steps();
        test_directed_rays();
        test_step_burst();
        test_random_rays();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Walked %0d ray loads and %0d voxel steps, including an unpaused burst.",
                 loads_sent, steps_sent);
        $display("Compared %0d voxel results, %0d failures.", results_checked, fail_count);
        if (fail_count == 0 && expected_voxels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
